// ===== src/hex_digit_trie_integer_set_core_assert.svh =====
// Assertion macros shared by the trie set core.
`ifndef HEX_DIGIT_TRIE_INTEGER_SET_CORE_ASSERT_SVH
`define HEX_DIGIT_TRIE_INTEGER_SET_CORE_ASSERT_SVH

// The consequence must hold in the same cycle as the antecedent.
`define HDT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define HDT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/hdt_pkg.sv =====
package hdt_pkg;

    // Key width is fixed by the item format.
    localparam int KEY_BITS = 32;

    // Default trie geometry.
    localparam int NODE_COUNT_DEF = 4096;
    localparam int RADIX_BITS_DEF = 4;

    // Item kinds.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // Input item.
    typedef struct packed {
        logic                       kind;
        logic signed [KEY_BITS-1:0] key;
    } t_hdt_in;

    // Result item.
    typedef struct packed {
        logic found;
        logic status;
    } t_hdt_out;

endpackage

// ===== src/hdt_ram.sv =====
module hdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/hex_digit_trie_integer_set_core.sv =====
// Channel   Direction  Handshake            Item
// input     in         i_valid / o_ready    i_data (kind, key)
// result    out        o_valid / i_ready    o_data (found, status)
//
// Zero goes from acceptance straight to FINISH, other keys first walk L digit levels
// (up to 8): link read, node read, then decide, per level.
// The input is ready again as the result loads; an item is held back in FINISH
// only while an earlier result waits unaccepted.
// After reset no clearing pass runs: a link counts only if its target node is
// allocated and records this very slot as its parent.
module hex_digit_trie_integer_set_core #(
    parameter int NODE_COUNT = hdt_pkg::NODE_COUNT_DEF,
    parameter int RADIX_BITS = hdt_pkg::RADIX_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  hdt_pkg::t_hdt_in  i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output hdt_pkg::t_hdt_out o_data
);

    import hdt_pkg::*;

    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int SLOT_W = NODE_W + RADIX_BITS;
    localparam int CNT_W  = $clog2(NODE_COUNT + 1);
    localparam int INFO_W = SLOT_W + 1;
    localparam int LINK_DEPTH = NODE_COUNT << RADIX_BITS;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_WALK   = 5'b00010,
        S_LINK   = 5'b00100,
        S_INFO   = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic                r_kind, n_kind;
    logic [KEY_BITS-1:0] r_mag, n_mag;
    logic [NODE_W-1:0]   r_node, n_node;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [NODE_W-1:0]   r_child, n_child;
    logic [CNT_W-1:0]    r_free, n_free;
    logic                r_mark0, n_mark0;
    logic                r_found, n_found;
    logic                r_status, n_status;
    logic                r_out_valid, n_out_valid;
    t_hdt_out            r_out, n_out;

    logic                link_we;
    logic [SLOT_W-1:0]   link_raddr;
    logic [NODE_W-1:0]   link_rdata;
    logic                info_we;
    logic [NODE_W-1:0]   info_waddr;
    logic [INFO_W-1:0]   info_wdata;
    logic [INFO_W-1:0]   info_rdata;

    logic                accept;
    logic                key_neg;
    logic [KEY_BITS-1:0] key_u;
    logic [KEY_BITS-1:0] key_mag;
    logic                last_level;
    logic                link_hit;
    logic                pool_full;

    // Link memory: one child index per (node, digit) slot.
    hdt_ram #(
        .WIDTH (NODE_W),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (r_slot),
        .i_wdata (r_free[NODE_W-1:0]),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    // Node memory: present mark and the slot that links to the node.
    hdt_ram #(
        .WIDTH (INFO_W),
        .DEPTH (NODE_COUNT)
    ) u_info_ram (
        .i_clk   (i_clk),
        .i_we    (info_we),
        .i_waddr (info_waddr),
        .i_wdata (info_wdata),
        .i_raddr (link_rdata),
        .o_rdata (info_rdata)
    );

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign accept  = i_valid && o_ready;

    // Magnitude of the incoming key; the most negative key gives 2^(KEY_BITS-1).
    assign key_u   = i_data.key;
    assign key_neg = key_u[KEY_BITS-1];
    assign key_mag = key_neg ? (KEY_BITS'(0) - key_u) : key_u;

    // Slot of the current level.
    assign link_raddr = {r_node, r_mag[RADIX_BITS-1:0]};

    // A stored link is real only if it targets an allocated non-root node
    // whose recorded parent slot is the slot just read.
    assign link_hit = (r_child >= NODE_W'(2))
                   && (CNT_W'(r_child) < r_free)
                   && (info_rdata[SLOT_W-1:0] == r_slot);
    assign last_level = (r_mag == '0);
    assign pool_full  = (r_free >= CNT_W'(NODE_COUNT));

    // Sequencer: one level per pass through WALK, LINK and INFO.
    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_mag       = r_mag;
        n_node      = r_node;
        n_slot      = r_slot;
        n_child     = r_child;
        n_free      = r_free;
        n_mark0     = r_mark0;
        n_found     = r_found;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        link_we     = 1'b0;
        info_we     = 1'b0;
        info_waddr  = r_child;
        info_wdata  = {1'b1, info_rdata[SLOT_W-1:0]};

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kind   = i_data.kind;
                    n_found  = 1'b0;
                    n_status = 1'b0;
                    n_mag    = key_mag;
                    n_node   = key_neg ? NODE_W'(1) : NODE_W'(0);
                    if (key_mag == '0) begin
                        // Zero lives on the positive root itself.
                        if (i_data.kind == KIND_INSERT) begin
                            n_mark0 = 1'b1;
                        end else begin
                            n_found = r_mark0;
                        end
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                // Read the link for the lowest digit and drop that digit.
                n_slot  = link_raddr;
                n_mag   = r_mag >> RADIX_BITS;
                n_state = S_LINK;
            end
            S_LINK: begin
                // The child index is out; its node record is being read.
                n_child = link_rdata;
                n_state = S_INFO;
            end
            S_INFO: begin
                if (link_hit) begin
                    if (last_level) begin
                        if (r_kind == KIND_INSERT) begin
                            info_we = 1'b1;
                        end else begin
                            n_found = info_rdata[SLOT_W];
                        end
                        n_state = S_FINISH;
                    end else begin
                        n_node  = r_child;
                        n_state = S_WALK;
                    end
                end else if (r_kind == KIND_LOOKUP) begin
                    n_state = S_FINISH;
                end else if (pool_full) begin
                    n_status = 1'b1;
                    n_state  = S_FINISH;
                end else begin
                    // Allocate the next node, link it and record its parent.
                    link_we    = 1'b1;
                    info_we    = 1'b1;
                    info_waddr = r_free[NODE_W-1:0];
                    info_wdata = {last_level, r_slot};
                    n_free     = r_free + CNT_W'(1);
                    n_node     = r_free[NODE_W-1:0];
                    n_state    = last_level ? S_FINISH : S_WALK;
                end
            end
            S_FINISH: begin
                // Load the result register once it is free.
                if (!r_out_valid || i_ready) begin
                    n_out.found  = r_found;
                    n_out.status = r_status;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free      <= CNT_W'(2);
            r_mark0     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free      <= n_free;
            r_mark0     <= n_mark0;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result payload.
    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_mag    <= n_mag;
        r_node   <= n_node;
        r_slot   <= n_slot;
        r_child  <= n_child;
        r_found  <= n_found;
        r_status <= n_status;
        r_out    <= n_out;
    end

    `include "hex_digit_trie_integer_set_core_assert.svh"

    // The free pointer stays between the two roots and the pool size.
    `HDT_ASSERT_SAME(a_free_range, 1'b1, (r_free >= CNT_W'(2)) && (r_free <= CNT_W'(NODE_COUNT)), "free pointer out of range")
    // Every allocation advances the free pointer by exactly one.
    `HDT_ASSERT_NEXT(a_alloc_step, link_we, r_free == $past(r_free) + CNT_W'(1), "allocation did not advance pointer")
    // A result never reports both a found key and an exhausted pool.
    `HDT_ASSERT_SAME(a_out_excl, o_valid, !(o_data.found && o_data.status), "found and full together")
    // A lookup never writes either memory.
    `HDT_ASSERT_SAME(a_lookup_ro, (r_state == S_INFO) && (r_kind == KIND_LOOKUP), !link_we && !info_we, "lookup wrote memory")

endmodule
